[hw/rtl/fwmf_pkg.sv]
// Shared constants and types of the flash-write message framer.
package fwmf_pkg;

    localparam int OFFSET_W    = 25;
    localparam int BYTE_W      = 8;
    localparam int CHUNK_BYTES = 128;
    localparam int ADDR_BYTES  = 4;
    localparam int HDR_EXTRA   = 2 + ADDR_BYTES;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] MSG_TYPE = 8'h09;

    // Position of an emitted byte within one message.
    localparam logic [2:0] POS_LEN   = 3'd0;
    localparam logic [2:0] POS_TYPE  = 3'd1;
    localparam logic [2:0] POS_OFF0  = 3'd2;
    localparam logic [2:0] POS_OFF1  = 3'd3;
    localparam logic [2:0] POS_OFF2  = 3'd4;
    localparam logic [2:0] POS_OFF3  = 3'd5;
    localparam logic [2:0] POS_DATA  = 3'd6;
    localparam logic [2:0] POS_CKSUM = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic                excess;
        logic                hdr;
        logic [BYTE_W-1:0]   len_byte;
        logic [OFFSET_W-1:0] offset;
        logic                last;
        logic                done;
    } cmd_t;

endpackage

[hw/rtl/fwmf_in_if.sv]
// Request channel carrying image bytes into the framer.
interface fwmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[hw/rtl/fwmf_out_if.sv]
// Request channel carrying message bytes out of the framer.
interface fwmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
    logic       image_done;
    logic       excess;

    modport source (output valid, output out_byte, output last_of_run, output frame_end,
                    output image_done, output excess, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input frame_end,
                    input image_done, input excess, output ready);
endinterface

[hw/rtl/fwmf_front.sv]
// Front end: accepts image bytes, tracks chunking and issues commands.
module fwmf_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fwmf_pkg::OFFSET_W-1:0] cfg_wdata,
    fwmf_in_if.sink                       din,
    input  logic                          q_full,
    output logic                          q_push,
    output fwmf_pkg::cmd_t                q_cmd
);

    logic [fwmf_pkg::OFFSET_W-1:0] image_length_reg;
    logic [fwmf_pkg::OFFSET_W-1:0] byte_offset_reg, byte_offset_next;
    logic [fwmf_pkg::BYTE_W-1:0]   chunk_left_reg, chunk_left_next;

    logic                          open_msg;
    logic                          is_excess;
    logic [fwmf_pkg::OFFSET_W-1:0] remaining;
    logic [fwmf_pkg::BYTE_W-1:0]   size;
    logic [fwmf_pkg::BYTE_W-1:0]   cur_left;
    logic [fwmf_pkg::BYTE_W-1:0]   left_after;
    logic [fwmf_pkg::OFFSET_W-1:0] offset_after;

    assign din.ready = !q_full;
    assign q_push    = din.valid && !q_full;

    always_comb
    begin
        open_msg     = chunk_left_reg != '0;
        is_excess    = !open_msg && (byte_offset_reg >= image_length_reg);
        remaining    = image_length_reg - byte_offset_reg;
        size         = (remaining > fwmf_pkg::OFFSET_W'(fwmf_pkg::CHUNK_BYTES))
                       ? fwmf_pkg::BYTE_W'(fwmf_pkg::CHUNK_BYTES)
                       : remaining[fwmf_pkg::BYTE_W-1:0];
        cur_left     = open_msg ? chunk_left_reg : size;
        left_after   = cur_left - 8'd1;
        offset_after = byte_offset_reg + 25'd1;

        q_cmd.data_byte = din.data_byte;
        q_cmd.excess    = is_excess;
        q_cmd.hdr       = !open_msg;
        q_cmd.len_byte  = size + fwmf_pkg::BYTE_W'(fwmf_pkg::HDR_EXTRA);
        q_cmd.offset    = byte_offset_reg;
        q_cmd.last      = left_after == '0;
        q_cmd.done      = (left_after == '0) && (offset_after >= image_length_reg);

        chunk_left_next  = chunk_left_reg;
        byte_offset_next = byte_offset_reg;
        if (q_push && !is_excess)
        begin
            chunk_left_next  = left_after;
            byte_offset_next = offset_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg <= '0;
            byte_offset_reg  <= '0;
            chunk_left_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                image_length_reg <= cfg_wdata;
            end
            byte_offset_reg <= byte_offset_next;
            chunk_left_reg  <= chunk_left_next;
        end
    end

endmodule

[hw/rtl/fwmf_queue.sv]
// Short command queue between the front and back ends.
module fwmf_queue
#(
    parameter int DEPTH = fwmf_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fwmf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output fwmf_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fwmf_pkg::cmd_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign head_cmd = entries_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/fwmf_back.sv]
// Back end: expands commands into message bytes and keeps the checksum.
module fwmf_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  fwmf_pkg::cmd_t head_cmd,
    output logic           q_pop,
    fwmf_out_if.source     dout
);

    logic [2:0] phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg, fend_reg, done_reg, exc_reg;

    logic       emit;
    logic [2:0] pos;
    logic [7:0] cur_byte;
    logic       final_byte;

    assign emit  = !q_empty && (!valid_reg || dout.ready);
    assign q_pop = emit && final_byte;

    always_comb
    begin
        // Commands without a header start directly at the payload byte.
        pos = head_cmd.hdr ? phase_reg : phase_reg + fwmf_pkg::POS_DATA;

        unique case (pos)
            fwmf_pkg::POS_LEN:   cur_byte = head_cmd.len_byte;
            fwmf_pkg::POS_TYPE:  cur_byte = fwmf_pkg::MSG_TYPE;
            fwmf_pkg::POS_OFF0:  cur_byte = head_cmd.offset[7:0];
            fwmf_pkg::POS_OFF1:  cur_byte = head_cmd.offset[15:8];
            fwmf_pkg::POS_OFF2:  cur_byte = head_cmd.offset[23:16];
            fwmf_pkg::POS_OFF3:  cur_byte = {7'd0, head_cmd.offset[24]};
            fwmf_pkg::POS_DATA:  cur_byte = head_cmd.data_byte;
            fwmf_pkg::POS_CKSUM: cur_byte = xor_reg;
            default:             cur_byte = head_cmd.data_byte;
        endcase

        final_byte = head_cmd.excess || (pos == fwmf_pkg::POS_CKSUM)
                     || ((pos == fwmf_pkg::POS_DATA) && !head_cmd.last);

        phase_next = phase_reg;
        xor_next   = xor_reg;
        if (emit)
        begin
            phase_next = final_byte ? 3'd0 : phase_reg + 3'd1;
            if (!head_cmd.excess)
            begin
                if (pos == fwmf_pkg::POS_LEN)
                begin
                    xor_next = cur_byte;
                end
                else if (pos == fwmf_pkg::POS_CKSUM)
                begin
                    xor_next = '0;
                end
                else
                begin
                    xor_next = xor_reg ^ cur_byte;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= head_cmd.excess ? 8'd0 : cur_byte;
            last_reg <= final_byte;
            fend_reg <= !head_cmd.excess && (pos == fwmf_pkg::POS_CKSUM);
            done_reg <= !head_cmd.excess && (pos == fwmf_pkg::POS_CKSUM) && head_cmd.done;
            exc_reg  <= head_cmd.excess;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            xor_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign dout.valid       = valid_reg;
    assign dout.out_byte    = byte_reg;
    assign dout.last_of_run = last_reg;
    assign dout.frame_end   = fend_reg;
    assign dout.image_done  = done_reg;
    assign dout.excess      = exc_reg;

endmodule

[hw/rtl/flash_write_message_framer.sv]
// Each accepted request is written into the command queue; the back end registers its message bytes for the output.
// The back end sends one message byte per cycle while the output port is ready; a request
// becomes 1 message byte, 2 with a checksum, 7 with a header, or 8 with both.
// The front end keeps taking requests while the command queue has room.
// Reset clears the image length, byte offset, open chunk, checksum, queue and output valid.
module flash_write_message_framer
#(
    parameter int QUEUE_DEPTH = fwmf_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fwmf_pkg::OFFSET_W-1:0] cfg_wdata,
    fwmf_in_if.sink                       din,
    fwmf_out_if.source                    dout
);

    logic           q_push, q_full, q_pop, q_empty;
    fwmf_pkg::cmd_t push_cmd, head_cmd;

    fwmf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .din       (din),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    fwmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    fwmf_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head_cmd (head_cmd),
        .q_pop    (q_pop),
        .dout     (dout)
    );

endmodule
